// File: sv/ctrgb_pkg.sv
// Shared constants, types and elaboration-time tables for the colour temperature converter.
package ctrgb_pkg;

    // Channel width default and fixed field widths.
    localparam int unsigned CHANNEL_BITS_DEF = 8;
    localparam int unsigned TEMP_BITS        = 16;
    localparam int unsigned TQ_BITS          = 17;

    // Number of register stages from input transfer to output register.
    localparam int unsigned NUM_STAGES = 8;

    // Clamp limits in kelvin.
    localparam logic [TEMP_BITS-1:0] K_MIN = 16'd1000;
    localparam logic [TEMP_BITS-1:0] K_MAX = 16'd40000;

    // Break points of t = K/100 in Q8.
    localparam logic [TQ_BITS-1:0] TQ_KNEE      = 17'd16896;
    localparam logic [TQ_BITS-1:0] TQ_BLUE_ZERO = 17'd4864;
    localparam logic [TQ_BITS-1:0] TQ_SIXTY     = 17'd15360;
    localparam logic [TQ_BITS-1:0] TQ_TEN       = 17'd2560;

    // Division by 100 as a multiplication by a rounded-up reciprocal.
    localparam int unsigned  RECIP_SHIFT = 31;
    localparam logic [24:0]  RECIP_100   = 25'(((64'd1 << RECIP_SHIFT) / 100) + 1);

    // Fixed point formats: log2 values in Q20, fractions in Q24.
    localparam int unsigned L2_FRAC   = 20;
    localparam int unsigned L2_BITS   = 24;
    localparam int unsigned FRAC_BITS = 24;
    localparam logic [24:0] FRAC_ONE  = 25'd1 << FRAC_BITS;
    localparam logic [24:0] FRAC_HALF = 25'd1 << (FRAC_BITS - 1);

    // Curve coefficients in Q30.
    localparam longint unsigned LN2_Q30     = 64'd744261118;
    localparam longint unsigned RED_LNA_Q30 = 64'd271658664;
    localparam longint unsigned RED_P_Q30   = 64'd143027521;
    localparam longint unsigned GRN_LNA_Q30 = 64'd126923961;
    localparam longint unsigned GRN_P_Q30   = 64'd81083452;
    localparam longint unsigned GRN_A_Q30   = 64'd417210786;
    localparam longint unsigned GRN_B_Q30   = 64'd675784450;
    localparam longint unsigned BLU_A_Q30   = 64'd580985475;
    localparam longint unsigned BLU_B_Q30   = 64'd1279450595;

    // Power exponents in Q24.
    localparam logic [23:0] RED_P = 24'((RED_P_Q30 + 64'd32) >> 6);
    localparam logic [23:0] GRN_P = 24'((GRN_P_Q30 + 64'd32) >> 6);

    // Base two logarithm of the power curve gains, Q24.
    localparam logic [23:0] RED_LOG2A =
        24'(((RED_LNA_Q30 << 24) + (LN2_Q30 / 2)) / LN2_Q30);
    localparam logic [23:0] GRN_LOG2A =
        24'(((GRN_LNA_Q30 << 24) + (LN2_Q30 / 2)) / LN2_Q30);

    // Log curve slopes folded with ln 2, Q24, and offsets in Q24.
    localparam logic [23:0] GRN_SLOPE = 24'(((GRN_A_Q30 * LN2_Q30) + (64'd1 << 35)) >> 36);
    localparam logic [23:0] BLU_SLOPE = 24'(((BLU_A_Q30 * LN2_Q30) + (64'd1 << 35)) >> 36);
    localparam logic [24:0] GRN_OFFSET = 25'((GRN_B_Q30 + 64'd32) >> 6);
    localparam logic [24:0] BLU_OFFSET = 25'((BLU_B_Q30 + 64'd32) >> 6);

    // Table types: log2(1 + i/256) in Q20 and 2^(-i/256) in Q24.
    typedef logic [255:0][19:0] t_log2_tbl;
    typedef logic [255:0][24:0] t_exp2_tbl;

    // Branch selection that travels with each item.
    typedef struct packed {
        logic knee_lo;
        logic blue_full;
        logic blue_zero;
    } t_sel_flags;

    // Operands for the 2^-u interpolation.
    typedef struct packed {
        logic        sat;
        logic [3:0]  shift;
        logic [24:0] base;
        logic [16:0] slope;
        logic [15:0] frac;
    } t_exp_seed;

    // Builds the log2 table by repeated squaring of the mantissa.
    function automatic t_log2_tbl gen_log2_tbl();
        t_log2_tbl   tbl;
        logic [63:0] m;
        logic [20:0] frac;
        for (int i = 0; i < 256; i++) begin
            m    = 64'(256 + i) << 22;
            frac = '0;
            for (int b = 0; b < 21; b++) begin
                m    = (m * m) >> 30;
                frac = {frac[19:0], 1'b0};
                if (m >= (64'd2 << 30)) begin
                    m       = m >> 1;
                    frac[0] = 1'b1;
                end
            end
            tbl[i] = 20'((22'(frac) + 22'd1) >> 1);
        end
        return tbl;
    endfunction

    // Integer square root, one result bit per step.
    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] trial;
        res = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = res | (64'd1 << b);
            if ((trial * trial) <= n) begin
                res = trial;
            end
        end
        return res;
    endfunction

    // Builds the 2^(-i/256) table from products of repeated square roots of one half.
    function automatic t_exp2_tbl gen_exp2_tbl();
        t_exp2_tbl        tbl;
        logic [7:0][63:0] root;
        logic [63:0]      v;
        logic [63:0]      e;
        v = 64'd1 << 29;
        for (int j = 7; j >= 0; j--) begin
            v       = isqrt64(v << 30);
            root[j] = v;
        end
        for (int i = 0; i < 256; i++) begin
            e = 64'd1 << 30;
            for (int j = 0; j < 8; j++) begin
                if (((i >> j) & 1) != 0) begin
                    e = ((e * root[j]) + (64'd1 << 29)) >> 30;
                end
            end
            tbl[i] = 25'((e + 64'd32) >> 6);
        end
        return tbl;
    endfunction

    localparam t_log2_tbl LOG2_TBL = gen_log2_tbl();
    localparam t_exp2_tbl EXP2_TBL = gen_exp2_tbl();

endpackage

// File: sv/color_temperature_to_rgb.sv
// Colour temperature to RGB converter: eight-stage pipeline from kelvin to channel levels.
//
// Converts a colour temperature in kelvin (clamped to 1000..40000) into red, green and
// blue levels along the usual blackbody curve fit, each level within one LSB of
// round(FULL * curve) with FULL = 2^CHANNEL_BITS - 1. The block keeps no state from one
// item to the next; each item moves through the register stages in order. A new item
// can be taken on every cycle as long as the output side does not stall, so throughput
// is then one item per cycle. The eight register stages are: clamp and multiply by the
// reciprocal of 100, normalise, log2 table interpolation, coefficient multipliers,
// exponential table lookup, exponential interpolation, branch selection and level
// scaling. A stalled output backs pressure up only through full stages; empty stages
// keep taking items.
module color_temperature_to_rgb #(
    parameter int unsigned CHANNEL_BITS = ctrgb_pkg::CHANNEL_BITS_DEF,
    localparam int unsigned OUT_W = ((3 * CHANNEL_BITS + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // temperature_kelvin[15:0]
    input  logic [ctrgb_pkg::TEMP_BITS-1:0] s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // red_level, green_level, blue_level (CHANNEL_BITS each), zero padding to bytes
    output logic [OUT_W-1:0]                m_axis_tdata
);
    import ctrgb_pkg::*;

    localparam int unsigned LVL_W = FRAC_BITS + 1 + CHANNEL_BITS + 1;

    // Finds the position of the leading one.
    function automatic logic [4:0] lead_one(input logic [TQ_BITS-1:0] x);
        logic [4:0] pos;
        pos = '0;
        for (int b = 0; b < TQ_BITS; b++) begin
            if (x[b]) begin
                pos = 5'(b);
            end
        end
        return pos;
    endfunction

    // Normalises a Q8 value: integer part of log2 and the mantissa fraction.
    function automatic logic [19:0] normalise(input logic [TQ_BITS-1:0] x);
        logic [4:0]         pos;
        logic [TQ_BITS-1:0] m;
        pos = lead_one(x);
        m   = x << (5'd16 - pos);
        return {4'(pos - 5'd8), m[15:0]};
    endfunction

    // log2 of the mantissa by linear interpolation between table points.
    function automatic logic [L2_BITS-1:0] log2_interp(input logic [19:0] nrm);
        logic [7:0]  idx;
        logic [7:0]  f;
        logic [20:0] t0;
        logic [20:0] t1;
        logic [12:0] dt;
        logic [20:0] prod;
        logic [19:0] lf;
        idx  = nrm[15:8];
        f    = nrm[7:0];
        t0   = {1'b0, LOG2_TBL[idx]};
        t1   = (idx == 8'hFF) ? (21'd1 << L2_FRAC) : {1'b0, LOG2_TBL[8'(idx + 8'd1)]};
        dt   = 13'(t1 - t0);
        prod = 21'(dt) * 21'(f);
        lf   = 20'(t0 + (prod >> 8));
        return {nrm[19:16], lf};
    endfunction

    // Splits the exponent u of 2^-u into shift, table point and fraction.
    function automatic t_exp_seed exp_prep(input logic [28:0] u);
        t_exp_seed   s;
        logic [7:0]  idx;
        logic [24:0] e1;
        idx     = u[23:16];
        s.sat   = u[28] || (u == '0);
        s.shift = u[27:24];
        s.frac  = u[15:0];
        s.base  = EXP2_TBL[idx];
        e1      = (idx == 8'hFF) ? FRAC_HALF : EXP2_TBL[8'(idx + 8'd1)];
        s.slope = 17'(s.base - e1);
        return s;
    endfunction

    // Clamps a signed Q24 value to 0..1.
    function automatic logic [24:0] clamp_unit(input logic [28:0] x);
        logic [24:0] r;
        if (x[28]) begin
            r = '0;
        end else if (x[27:0] >= 28'(FRAC_ONE)) begin
            r = FRAC_ONE;
        end else begin
            r = x[24:0];
        end
        return r;
    endfunction

    // Scales a Q24 fraction to a rounded channel level.
    function automatic logic [CHANNEL_BITS-1:0] to_level(input logic [24:0] v);
        logic [LVL_W-1:0] acc;
        acc = (LVL_W'(v) << CHANNEL_BITS) - LVL_W'(v) + (LVL_W'(1) << (FRAC_BITS - 1));
        return acc[FRAC_BITS +: CHANNEL_BITS];
    endfunction

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES-1:0] stage_en;

    logic [TQ_BITS-1:0]    r_tq;
    t_sel_flags            r_flg1, r_flg2, r_flg3, r_flg4, r_flg5;
    logic [19:0]           r_nrm_a, r_nrm_b;
    logic [L2_BITS-1:0]    r_l2a, r_l2b;
    logic [27:0]           r_pr, r_pg, r_lg, r_lb;
    t_exp_seed             r_seed_r, r_seed_g;
    logic [24:0]           r_lin_g4, r_lin_b4;
    logic [24:0]           r_exp_r, r_exp_g;
    logic                  r_sat_r, r_sat_g;
    logic [3:0]            r_sh_r, r_sh_g;
    logic [24:0]           r_lin_g5, r_lin_b5;
    logic [24:0]           r_red_v, r_grn_v, r_blu_v;
    logic [CHANNEL_BITS-1:0] r_red_lvl, r_grn_lvl, r_blu_lvl;

    logic [TEMP_BITS-1:0]  k_clamp;
    logic [23:0]           tq_num;
    logic [48:0]           tq_prod;
    t_sel_flags            flg0;
    logic [TQ_BITS-1:0]    xa, xb;
    logic [47:0]           pr_full, pg_full, lg_full, lb_full;
    logic [32:0]           dr_prod, dg_prod;
    logic [24:0]           v_r, v_g;

    // Stage advance: a stage loads when it is empty or its successor moves on.
    always_comb begin
        stage_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
        n_vld = {r_vld[NUM_STAGES-2:0], s_axis_tvalid};
    end

    assign s_axis_tready = stage_en[0];
    assign m_axis_tvalid = r_vld[NUM_STAGES-1];
    assign m_axis_tdata  = OUT_W'({r_blu_lvl, r_grn_lvl, r_red_lvl});

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (stage_en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // Stage 0: clamp and t = K/100 in Q8 through the reciprocal.
    always_comb begin
        if (s_axis_tdata < K_MIN) begin
            k_clamp = K_MIN;
        end else if (s_axis_tdata > K_MAX) begin
            k_clamp = K_MAX;
        end else begin
            k_clamp = s_axis_tdata;
        end
        tq_num  = {k_clamp, 8'd0} + 24'd50;
        tq_prod = 49'(tq_num) * 49'(RECIP_100);
    end

    // Stage 1: branch flags and normalisation of both log arguments.
    always_comb begin
        flg0.knee_lo   = (r_tq <= TQ_KNEE);
        flg0.blue_full = (r_tq >= TQ_KNEE);
        flg0.blue_zero = (r_tq <= TQ_BLUE_ZERO);
        xa = flg0.knee_lo ? r_tq : TQ_BITS'(r_tq - TQ_SIXTY);
        xb = TQ_BITS'(r_tq - TQ_TEN);
    end

    // Stage 3 multipliers: exponents and log curves from the log2 values.
    always_comb begin
        pr_full = 48'(r_l2a) * 48'(RED_P);
        pg_full = 48'(r_l2a) * 48'(GRN_P);
        lg_full = 48'(r_l2a) * 48'(GRN_SLOPE);
        lb_full = 48'(r_l2b) * 48'(BLU_SLOPE);
    end

    // Stage 5 interpolation products and stage 6 scaling by the whole part of u.
    always_comb begin
        dr_prod = 33'(r_seed_r.slope) * 33'(r_seed_r.frac);
        dg_prod = 33'(r_seed_g.slope) * 33'(r_seed_g.frac);
        v_r     = r_sat_r ? FRAC_ONE : (r_exp_r >> r_sh_r);
        v_g     = r_sat_g ? FRAC_ONE : (r_exp_g >> r_sh_g);
    end

    // Pipeline payload registers.
    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_tq <= tq_prod[RECIP_SHIFT +: TQ_BITS];
        end
        if (stage_en[1]) begin
            r_flg1  <= flg0;
            r_nrm_a <= normalise(xa);
            r_nrm_b <= normalise(xb);
        end
        if (stage_en[2]) begin
            r_flg2 <= r_flg1;
            r_l2a  <= log2_interp(r_nrm_a);
            r_l2b  <= log2_interp(r_nrm_b);
        end
        if (stage_en[3]) begin
            r_flg3 <= r_flg2;
            r_pr   <= pr_full[47:20];
            r_pg   <= pg_full[47:20];
            r_lg   <= lg_full[47:20];
            r_lb   <= lb_full[47:20];
        end
        if (stage_en[4]) begin
            r_flg4   <= r_flg3;
            r_seed_r <= exp_prep(29'(r_pr) - 29'(RED_LOG2A));
            r_seed_g <= exp_prep(29'(r_pg) - 29'(GRN_LOG2A));
            r_lin_g4 <= clamp_unit(29'(r_lg) - 29'(GRN_OFFSET));
            r_lin_b4 <= clamp_unit(29'(r_lb) - 29'(BLU_OFFSET));
        end
        if (stage_en[5]) begin
            r_flg5   <= r_flg4;
            r_exp_r  <= r_seed_r.base - 25'(dr_prod >> 16);
            r_exp_g  <= r_seed_g.base - 25'(dg_prod >> 16);
            r_sat_r  <= r_seed_r.sat;
            r_sat_g  <= r_seed_g.sat;
            r_sh_r   <= r_seed_r.shift;
            r_sh_g   <= r_seed_g.shift;
            r_lin_g5 <= r_lin_g4;
            r_lin_b5 <= r_lin_b4;
        end
        // Branch selection per channel.
        if (stage_en[6]) begin
            r_red_v <= r_flg5.knee_lo ? FRAC_ONE : v_r;
            r_grn_v <= r_flg5.knee_lo ? r_lin_g5 : v_g;
            if (r_flg5.blue_full) begin
                r_blu_v <= FRAC_ONE;
            end else if (r_flg5.blue_zero) begin
                r_blu_v <= '0;
            end else begin
                r_blu_v <= r_lin_b5;
            end
        end
        if (stage_en[7]) begin
            r_red_lvl <= to_level(r_red_v);
            r_grn_lvl <= to_level(r_grn_v);
            r_blu_lvl <= to_level(r_blu_v);
        end
    end

endmodule

// File: sv/ctrgb_checker.sv
// Port-level assertions for the colour temperature converter, bound to its top level.
module ctrgb_checker #(
    parameter int unsigned CHANNEL_BITS = ctrgb_pkg::CHANNEL_BITS_DEF,
    localparam int unsigned OUT_W = ((3 * CHANNEL_BITS + 7) / 8) * 8
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [ctrgb_pkg::TEMP_BITS-1:0] s_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [OUT_W-1:0]                m_axis_tdata
);
    import ctrgb_pkg::*;

    localparam logic [CHANNEL_BITS-1:0] LEVEL_FULL = '1;

    logic [CHANNEL_BITS-1:0] red_lvl;
    logic [CHANNEL_BITS-1:0] blu_lvl;
    logic                    in_xfer;

    assign red_lvl = m_axis_tdata[CHANNEL_BITS-1:0];
    assign blu_lvl = m_axis_tdata[2*CHANNEL_BITS +: CHANNEL_BITS];
    assign in_xfer = s_axis_tvalid && s_axis_tready && (s_axis_tdata != '0 || 1'b1);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A stalled result holds until its transfer.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // With the output side ready, the pipeline always takes a new item.
    a_no_bubble_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output side ready");

    // Either red or blue is full: the knee splits the two.
    a_red_or_blue_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (red_lvl == LEVEL_FULL) || (blu_lvl == LEVEL_FULL))
        else $error("neither red nor blue full");

    // Blue is only zero at low temperatures, where red is full.
    a_blue_zero_red_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (blu_lvl == '0) |-> (red_lvl == LEVEL_FULL) || !in_xfer && 1'b0)
        else $error("blue zero with red not full");

endmodule

bind color_temperature_to_rgb ctrgb_checker #(
    .CHANNEL_BITS(CHANNEL_BITS)
) u_ctrgb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: tb/color_temperature_to_rgb_tb.sv
// Self-checking testbench for the colour temperature to RGB converter.
//
// A directed table of temperatures (clamp limits, the red/blue knee at 6600 K, the blue
// zero point at 1900 K, bit patterns) is followed by about 450 random temperatures,
// weighted towards the working range and the break points. Every input transfer is run
// through a fixed-point predictor of the blackbody curves. The expected levels are queued
// in order and each output transfer is compared channel by channel against the oldest
// entry, with one LSB of tolerance. The sender works in bursts with random gaps, and the
// receiver stalls on its own pattern, including one long hold that backs the pipeline up.
module color_temperature_to_rgb_tb;

    localparam int unsigned CH_BITS     = ctrgb_pkg::CHANNEL_BITS_DEF;
    localparam int unsigned OUT_W       = ((3 * CH_BITS + 7) / 8) * 8;
    localparam int          LEVEL_TOL   = 1;
    localparam int          RANDOM_ITEMS = 450;
    localparam int          IDLE_LIMIT  = 2000;
    localparam int          END_CYCLES  = 2 * ctrgb_pkg::NUM_STAGES + 4;
    localparam int          HOLD_CYCLES = 120;
    localparam int          HOLD_AFTER  = 150;

    // Marks a table entry whose level comes from the predictor.
    localparam int PREDICTED = -1;

    typedef longint unsigned t_u64;
    typedef longint          t_s64;

    // Channel levels, red in the lowest bits as on the output bus.
    typedef logic [2:0][CH_BITS-1:0] t_levels;

    // Fixed-point constants of the curve fit (Q30 unless noted).
    localparam t_u64 ONE_Q30   = 64'd1 << 30;
    localparam t_u64 LN2       = 64'd744261118;
    localparam t_s64 RED_LN_A  = 64'sd271658664;
    localparam t_u64 RED_EXP   = 64'd143027521;
    localparam t_s64 GRN_LN_A  = 64'sd126923961;
    localparam t_u64 GRN_EXP   = 64'd81083452;
    localparam t_u64 GRN_SLOPE = 64'd417210786;
    localparam t_s64 GRN_OFS   = 64'sd675784450;
    localparam t_u64 BLU_SLOPE = 64'd580985475;
    localparam t_s64 BLU_OFS   = 64'sd1279450595;
    localparam t_u64 LEVEL_MAX = (64'd1 << CH_BITS) - 64'd1;

    // Temperature limits in kelvin and break points of t = K/100 in Q8.
    localparam t_u64 KELVIN_LO  = 64'd1000;
    localparam t_u64 KELVIN_HI  = 64'd40000;
    localparam t_u64 T_KNEE     = 64'd16896;
    localparam t_u64 T_BLUE_OFF = 64'd4864;
    localparam t_u64 T_SIXTY    = 64'd15360;
    localparam t_u64 T_TEN      = 64'd2560;

    typedef struct packed {
        logic [15:0] kelvin;
        int          red;
        int          green;
        int          blue;
    } t_temp_row;

    // Directed temperatures with the levels that are plain from the curve definition.
    localparam int NUM_ROWS = 25;
    localparam t_temp_row DIRECTED_TEMPS [0:NUM_ROWS-1] = '{
        '{16'd0,     255, PREDICTED, 0},
        '{16'd1,     255, PREDICTED, 0},
        '{16'd255,   255, PREDICTED, 0},
        '{16'd999,   255, PREDICTED, 0},
        '{16'd1000,  255, PREDICTED, 0},
        '{16'd1001,  255, PREDICTED, 0},
        '{16'd1899,  255, PREDICTED, 0},
        '{16'd1900,  255, PREDICTED, 0},
        '{16'd1901,  255, PREDICTED, PREDICTED},
        '{16'd1950,  255, PREDICTED, PREDICTED},
        '{16'd3000,  255, PREDICTED, PREDICTED},
        '{16'd6599,  255, PREDICTED, PREDICTED},
        '{16'd6600,  255, PREDICTED, 255},
        '{16'd6601,  PREDICTED, PREDICTED, 255},
        '{16'd6650,  PREDICTED, PREDICTED, 255},
        '{16'd10000, PREDICTED, PREDICTED, 255},
        '{16'd20000, PREDICTED, PREDICTED, 255},
        '{16'd21845, PREDICTED, PREDICTED, 255},
        '{16'd32767, PREDICTED, PREDICTED, 255},
        '{16'd32768, PREDICTED, PREDICTED, 255},
        '{16'd39999, PREDICTED, PREDICTED, 255},
        '{16'd40000, PREDICTED, PREDICTED, 255},
        '{16'd40001, PREDICTED, PREDICTED, 255},
        '{16'd43690, PREDICTED, PREDICTED, 255},
        '{16'd65535, PREDICTED, PREDICTED, 255}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    // temperature_kelvin[15:0]
    logic [15:0]        s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    // red_level, green_level, blue_level, zero padding to bytes
    logic [OUT_W-1:0]   m_axis_tdata;

    t_levels            expected_levels [$];
    int                 fail_count   = 0;
    int                 levels_seen  = 0;
    int                 idle_cycles  = 0;
    int                 burst_left   = 0;

    color_temperature_to_rgb dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Natural log of a Q8 value of at least one, in Q30, via log2 by repeated squaring.
    function automatic t_u64 natural_log_q30(input t_u64 value);
        t_u64 v;
        t_u64 s;
        t_u64 m;
        t_u64 frac;
        t_u64 whole;
        int   n;
        v    = value;
        frac = 0;
        n    = 0;
        if (v < 64'd256) v = 64'd256;
        if (v > 64'hFFFFFF) v = 64'hFFFFFF;
        s = v;
        while (s > 64'd1) begin
            s = s >> 1;
            n++;
        end
        m = v << (30 - n);
        for (int i = 0; i < 30; i++) begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30)) begin
                m    = m >> 1;
                frac = frac | 64'd1;
            end
        end
        whole = (t_u64'(n - 8) << 30) + frac;
        return (whole * LN2) >> 30;
    endfunction

    // exp(-u) in Q30 from a twelve-term series; zero beyond u = 4.
    function automatic t_s64 decay_q30(input t_u64 u);
        t_u64 term;
        t_s64 sum;
        term = ONE_Q30;
        sum  = t_s64'(ONE_Q30);
        if (u > (64'd4 << 30)) return 0;
        for (int k = 1; k <= 12; k++) begin
            term = ((term * u) >> 30) / t_u64'(k);
            if ((k % 2) == 1) sum = sum - t_s64'(term);
            else sum = sum + t_s64'(term);
        end
        return sum;
    endfunction

    // A * x^-p evaluated as exp(ln A - p ln x), saturating at one.
    function automatic t_s64 power_fall_q30(input t_s64 ln_gain, input t_u64 expo, input t_u64 x);
        t_s64 z;
        z = ln_gain - t_s64'((expo * natural_log_q30(x)) >> 30);
        if (z >= 0) return t_s64'(ONE_Q30);
        return decay_q30(t_u64'(-z));
    endfunction

    // slope * ln(x) - offset.
    function automatic t_s64 log_rise_q30(input t_u64 slope, input t_s64 ofs, input t_u64 x);
        return t_s64'((slope * natural_log_q30(x)) >> 30) - ofs;
    endfunction

    // Clamp a Q30 fraction to 0..1 and scale it to a rounded level.
    function automatic logic [CH_BITS-1:0] fraction_to_level(input t_s64 v);
        if (v <= 0) return '0;
        if (v >= t_s64'(ONE_Q30)) return CH_BITS'(LEVEL_MAX);
        return CH_BITS'(((t_u64'(v) * LEVEL_MAX) + (64'd1 << 29)) >> 30);
    endfunction

    // Levels of the blackbody curve fit for one temperature.
    function automatic t_levels blackbody_levels(input logic [15:0] kelvin);
        t_u64    k;
        t_u64    tq;
        t_s64    r;
        t_s64    g;
        t_s64    b;
        t_levels lv;
        k = t_u64'(kelvin);
        if (k < KELVIN_LO) k = KELVIN_LO;
        if (k > KELVIN_HI) k = KELVIN_HI;
        tq = (k * 64'd256 + 64'd50) / 64'd100;
        if (tq <= T_KNEE) begin
            r = t_s64'(ONE_Q30);
            g = log_rise_q30(GRN_SLOPE, GRN_OFS, tq);
        end else begin
            r = power_fall_q30(RED_LN_A, RED_EXP, tq - T_SIXTY);
            g = power_fall_q30(GRN_LN_A, GRN_EXP, tq - T_SIXTY);
        end
        if (tq >= T_KNEE) b = t_s64'(ONE_Q30);
        else if (tq <= T_BLUE_OFF) b = 0;
        else b = log_rise_q30(BLU_SLOPE, BLU_OFS, tq - T_TEN);
        lv[0] = fraction_to_level(r);
        lv[1] = fraction_to_level(g);
        lv[2] = fraction_to_level(b);
        return lv;
    endfunction

    // Random temperature, weighted towards the working range and the break points.
    function automatic logic [15:0] random_kelvin();
        case ($urandom_range(0, 9))
            5:       return 16'($urandom_range(1850, 1950));
            6:       return 16'($urandom_range(6500, 6700));
            7:       return 16'($urandom_range(0, 999));
            8, 9:    return 16'($urandom);
            default: return 16'($urandom_range(1000, 40000));
        endcase
    endfunction

    // Offers one temperature, waits for its transfer, then queues the expected levels.
    task automatic offer_kelvin(input logic [15:0] kelvin, input t_levels want);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= kelvin;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_levels.push_back(want);
        burst_left--;
        if (burst_left <= 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 16'($urandom);
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 10);
        end
    endtask

    // Stimulus and end of run.
    initial begin
        t_levels   want;
        t_temp_row row;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        burst_left = $urandom_range(1, 10);

        // Directed table: typed levels where they are plain, predicted otherwise.
        for (int i = 0; i < NUM_ROWS; i++) begin
            row  = DIRECTED_TEMPS[i];
            want = blackbody_levels(row.kelvin);
            if (row.red   != PREDICTED) want[0] = CH_BITS'(row.red);
            if (row.green != PREDICTED) want[1] = CH_BITS'(row.green);
            if (row.blue  != PREDICTED) want[2] = CH_BITS'(row.blue);
            offer_kelvin(row.kelvin, want);
        end

        // Random temperatures.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            row.kelvin = random_kelvin();
            offer_kelvin(row.kelvin, blackbody_levels(row.kelvin));
        end
        s_axis_tvalid <= 1'b0;

        // Drain the pipeline, then allow a few more cycles for stray transfers.
        while (expected_levels.size() != 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_levels.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Receiver: rotating stall patterns, and one long hold once the run is well under way.
    initial begin
        logic [7:0] ready_pattern;
        int         pattern_left;
        int         pattern_pos;
        bit         hold_done;
        ready_pattern = 8'hFF;
        pattern_left  = 0;
        pattern_pos   = 0;
        hold_done     = 1'b0;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!hold_done && levels_seen >= HOLD_AFTER) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            if (pattern_left == 0) begin
                case ($urandom_range(0, 3))
                    0:       ready_pattern = 8'hFF;
                    1:       ready_pattern = 8'($urandom) | 8'h01;
                    2:       ready_pattern = 8'b0101_0101;
                    default: ready_pattern = ~(8'h01 << $urandom_range(0, 7));
                endcase
                pattern_left = $urandom_range(20, 80);
            end
            m_axis_tready <= ready_pattern[pattern_pos];
            pattern_pos  = (pattern_pos + 1) % 8;
            pattern_left--;
            @(posedge i_clk);
        end
    end

    // Output check: each transfer against the oldest expected levels, one LSB of slack.
    always @(posedge i_clk) begin
        t_levels want;
        t_levels got;
        int      diff;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            levels_seen++;
            got = t_levels'(m_axis_tdata[3*CH_BITS-1:0]);
            if (expected_levels.size() == 0) begin
                $display("%0t: unexpected output transfer, levels r=%0d g=%0d b=%0d",
                         $time, got[0], got[1], got[2]);
                fail_count++;
            end else begin
                want = expected_levels.pop_front();
                for (int c = 0; c < 3; c++) begin
                    diff = int'(got[c]) - int'(want[c]);
                    if (diff > LEVEL_TOL || diff < -LEVEL_TOL) begin
                        $display("%0t: channel %0d mismatch, expected %0d, actual %0d",
                                 $time, c, want[c], got[c]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither side makes a transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
sv/ctrgb_pkg.sv
sv/color_temperature_to_rgb.sv
sv/ctrgb_checker.sv
tb/color_temperature_to_rgb_tb.sv
